@@ hdl/rgim_pkg.sv @@
// Package: types, widths and constants shared by the ROI to ground-truth IoU matcher.
package rgim_pkg;

  localparam int MAX_GT_DEF     = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int FIELD_W = 16;               // coordinate field width
  localparam int CW      = 17;               // internal coordinate width
  localparam int SW      = 19;               // side / intersection width
  localparam int PW      = 33;               // area width
  localparam int UW      = 34;               // union width
  localparam int QW      = 17;               // Q1.16 overlap width
  localparam int THR_W   = 17;

  localparam logic signed [SW-1:0] ONE_PIXEL = SW'(16);
  localparam logic [QW-1:0]        ONE_Q16   = 17'h10000;

  localparam logic [THR_W-1:0] FG_RST  = 17'd32768;
  localparam logic [THR_W-1:0] BGH_RST = 17'd32768;
  localparam logic [THR_W-1:0] BGL_RST = 17'd0;

  typedef enum logic [1:0] {
    REG_FG  = 2'd0,
    REG_BGH = 2'd1,
    REG_BGL = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_CLEARED = 2'd0,
    ST_STORED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_QUERY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_S1, S_S2, S_S3, S_DS, S_DW, S_UPD, S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  coord0;
    logic signed [15:0]  coord1;
    logic signed [15:0]  coord2;
    logic signed [15:0]  coord3;
    logic signed [15:0]  coord4;
    logic signed [15:0]  coord5;
    logic signed [15:0]  coord6;
    logic signed [15:0]  coord7;
    logic [7:0]          class_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  best_index;
    logic [16:0] max_overlap;
    logic [7:0]  class_label;
    logic        is_fg;
    logic        is_bg;
  } out_t;

  typedef struct packed {
    logic [7:0]             cls;
    logic signed [CW-1:0]   xmin;
    logic signed [CW-1:0]   ymin;
    logic signed [CW-1:0]   xmax;
    logic signed [CW-1:0]   ymax;
  } gt_ent_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr;
    logic    wr;
    logic    init;
    logic    rd;
    logic    s1;
    logic    s2;
    logic    s3;
    logic    div_start;
    logic    upd;
    logic    k_inc;
    logic    emit;
    status_t code;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
    logic div_done;
  } sts_t;

  function automatic logic signed [CW-1:0] coord_ext(input logic [FIELD_W-1:0] raw,
                                                    input int unsigned cb);
    logic [CW-1:0] m;
    logic [CW-1:0] v;
    logic [CW-1:0] off;
    m   = (cb >= 16) ? 17'h0FFFF : ((17'd1 << cb) - 17'd1);
    v   = {1'b0, raw} & m;
    off = '0;
    if (cb <= 16 && ((v >> (cb - 1)) & 17'd1) != 17'd0) begin
      off = 17'd1 << cb;
    end
    return $signed(v - off);
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ hdl/rgim_div.sv @@
// Restoring divider: one quotient bit per cycle, 17-bit Q1.16 quotient.
module rgim_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rgim_pkg::PW-1:0]  num,
  input  logic [rgim_pkg::UW-1:0]  den,
  output logic                     done,
  output logic [rgim_pkg::QW-1:0]  quo
);

  logic [rgim_pkg::UW-1:0] rem_r, rem_nxt;
  logic [rgim_pkg::UW-1:0] den_r;
  logic [rgim_pkg::QW-1:0] q_r, q_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic                    run_r, run_nxt;
  logic                    first_r, first_nxt;
  logic                    done_r, done_nxt;
  logic [rgim_pkg::UW:0]   sh;
  logic                    qbit;

  always_comb begin
    sh        = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    qbit      = (sh >= {1'b0, den_r});
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    if (start) begin
      rem_nxt   = {1'b0, num};
      q_nxt     = '0;
      cnt_nxt   = 5'(rgim_pkg::QW - 1);
      run_nxt   = 1'b1;
      first_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt   = qbit ? rgim_pkg::UW'(sh - {1'b0, den_r}) : rgim_pkg::UW'(sh);
      q_nxt     = {q_r[rgim_pkg::QW-2:0], qbit};
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ hdl/rgim_dp.sv @@
// Datapath: ground-truth table, IoU pipeline, best-match tracking and result register.
module rgim_dp #(
  parameter int MAX_GT     = rgim_pkg::MAX_GT_DEF,
  parameter int COORD_BITS = rgim_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgim_pkg::in_t               in_data,
  input  rgim_pkg::ctl_t              ctl,
  output rgim_pkg::sts_t              sts,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rgim_pkg::THR_W-1:0]  cfg_data,
  output logic                        out_valid,
  output rgim_pkg::out_t              out_data
);

  localparam int AW   = (MAX_GT > 1) ? $clog2(MAX_GT) : 1;
  localparam int CNTW = $clog2(MAX_GT + 1);
  localparam int CW   = rgim_pkg::CW;
  localparam int SW   = rgim_pkg::SW;
  localparam int PW   = rgim_pkg::PW;
  localparam int UW   = rgim_pkg::UW;
  localparam int QW   = rgim_pkg::QW;

  rgim_pkg::gt_ent_t mem [MAX_GT];
  rgim_pkg::gt_ent_t mem_q_r;
  rgim_pkg::gt_ent_t wr_ent;

  logic [CNTW-1:0] cnt_r, k_r;
  logic [rgim_pkg::THR_W-1:0] fg_r, bgh_r, bgl_r;

  logic signed [CW-1:0] r0_r, r1_r, r2_r, r3_r;
  logic signed [CW-1:0] c [8];

  logic signed [SW-1:0] iw_r, ih_r, rw_r, rh_r, gw_r, gh_r;
  logic signed [2*SW-1:0] p_inter, p_ra, p_ga;
  logic [PW-1:0] inter_r, ra_r, ga_r;
  logic          hit_r;
  logic [PW-1:0] num_r;
  logic [UW-1:0] den_r, uni;

  logic          div_done;
  logic [QW-1:0] div_q;

  logic [QW-1:0] best_ov_r;
  logic [AW-1:0] best_idx_r;
  logic [7:0]    best_lbl_r;

  logic           out_valid_r;
  rgim_pkg::out_t out_r, out_nxt;

  always_comb begin
    c[0] = rgim_pkg::coord_ext(in_data.coord0, COORD_BITS);
    c[1] = rgim_pkg::coord_ext(in_data.coord1, COORD_BITS);
    c[2] = rgim_pkg::coord_ext(in_data.coord2, COORD_BITS);
    c[3] = rgim_pkg::coord_ext(in_data.coord3, COORD_BITS);
    c[4] = rgim_pkg::coord_ext(in_data.coord4, COORD_BITS);
    c[5] = rgim_pkg::coord_ext(in_data.coord5, COORD_BITS);
    c[6] = rgim_pkg::coord_ext(in_data.coord6, COORD_BITS);
    c[7] = rgim_pkg::coord_ext(in_data.coord7, COORD_BITS);
    wr_ent.cls  = in_data.class_in;
    wr_ent.xmin = rgim_pkg::smin(rgim_pkg::smin(c[0], c[2]), rgim_pkg::smin(c[4], c[6]));
    wr_ent.xmax = rgim_pkg::smax(rgim_pkg::smax(c[0], c[2]), rgim_pkg::smax(c[4], c[6]));
    wr_ent.ymin = rgim_pkg::smin(rgim_pkg::smin(c[1], c[3]), rgim_pkg::smin(c[5], c[7]));
    wr_ent.ymax = rgim_pkg::smax(rgim_pkg::smax(c[1], c[3]), rgim_pkg::smax(c[5], c[7]));
  end

  // table memory
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[cnt_r[AW-1:0]] <= wr_ent;
    end
    if (ctl.rd) begin
      mem_q_r <= mem[k_r[AW-1:0]];
    end
  end

  assign sts.full     = (cnt_r == CNTW'(MAX_GT));
  assign sts.empty    = (cnt_r == '0);
  assign sts.last     = (k_r == cnt_r - CNTW'(1));
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fg_r  <= rgim_pkg::FG_RST;
      bgh_r <= rgim_pkg::BGH_RST;
      bgl_r <= rgim_pkg::BGL_RST;
    end else begin
      if (ctl.clr) begin
        cnt_r <= '0;
      end else if (ctl.wr) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (cfg_we) begin
        unique case (rgim_pkg::reg_idx_t'(cfg_index))
          rgim_pkg::REG_FG:   fg_r  <= cfg_data;
          rgim_pkg::REG_BGH:  bgh_r <= cfg_data;
          rgim_pkg::REG_BGL:  bgl_r <= cfg_data;
          rgim_pkg::REG_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // IoU pipeline
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      r0_r       <= c[0];
      r1_r       <= c[1];
      r2_r       <= c[2];
      r3_r       <= c[3];
      k_r        <= '0;
      best_ov_r  <= '0;
      best_idx_r <= '0;
      best_lbl_r <= '0;
    end
    if (ctl.k_inc) begin
      k_r <= k_r + CNTW'(1);
    end
    if (ctl.s1) begin
      iw_r <= SW'(rgim_pkg::smin(r2_r, mem_q_r.xmax)) - SW'(rgim_pkg::smax(r0_r, mem_q_r.xmin))
              + rgim_pkg::ONE_PIXEL;
      ih_r <= SW'(rgim_pkg::smin(r3_r, mem_q_r.ymax)) - SW'(rgim_pkg::smax(r1_r, mem_q_r.ymin))
              + rgim_pkg::ONE_PIXEL;
      rw_r <= SW'(r2_r) - SW'(r0_r) + rgim_pkg::ONE_PIXEL;
      rh_r <= SW'(r3_r) - SW'(r1_r) + rgim_pkg::ONE_PIXEL;
      gw_r <= SW'(mem_q_r.xmax) - SW'(mem_q_r.xmin) + rgim_pkg::ONE_PIXEL;
      gh_r <= SW'(mem_q_r.ymax) - SW'(mem_q_r.ymin) + rgim_pkg::ONE_PIXEL;
    end
    if (ctl.s2) begin
      hit_r   <= (iw_r > 0) && (ih_r > 0);
      inter_r <= p_inter[PW-1:0];
      ra_r    <= p_ra[PW-1:0];
      ga_r    <= p_ga[PW-1:0];
    end
    if (ctl.s3) begin
      num_r <= hit_r ? inter_r : '0;
      den_r <= hit_r ? uni : UW'(1);
    end
    if (ctl.upd && (k_r == '0 || div_q > best_ov_r)) begin
      best_ov_r  <= div_q;
      best_idx_r <= k_r[AW-1:0];
      best_lbl_r <= mem_q_r.cls;
    end
  end

  assign p_inter = iw_r * ih_r;
  assign p_ra    = rw_r * rh_r;
  assign p_ga    = gw_r * gh_r;
  assign uni     = {1'b0, ra_r} + {1'b0, ga_r} - {1'b0, inter_r};

  rgim_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // result register
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = ctl.code;
    if (ctl.code == rgim_pkg::ST_QUERY) begin
      out_nxt.best_index  = 6'(best_idx_r);
      out_nxt.max_overlap = best_ov_r;
      out_nxt.class_label = best_lbl_r;
      out_nxt.is_fg       = ({1'b0, best_ov_r} >= {1'b0, fg_r});
      out_nxt.is_bg       = (best_ov_r >= bgl_r) && (best_ov_r < bgh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
    if (ctl.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_GT))
    else $error("table count above capacity");

  a_ov_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_q <= rgim_pkg::ONE_Q16)
    else $error("overlap above 1.0");

  a_nonquery_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != rgim_pkg::ST_QUERY) |->
      (out_r.max_overlap == '0 && out_r.best_index == '0 && out_r.class_label == '0
       && !out_r.is_fg && !out_r.is_bg))
    else $error("non-query transaction carries match fields");

  a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr |-> !sts.full)
    else $error("store into full table");

endmodule

@@ hdl/rgim_ctrl.sv @@
// Controller: command decode and the per-box sequence of a query.
module rgim_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_cmd,
  input  rgim_pkg::sts_t  sts,
  output rgim_pkg::ctl_t  ctl,
  output logic            busy
);

  rgim_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgim_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    ctl.code  = rgim_pkg::ST_CLEARED;
    state_nxt = state_r;
    unique case (state_r)
      rgim_pkg::S_IDLE: begin
        if (start) begin
          unique case (rgim_pkg::cmd_code_t'(in_cmd))
            rgim_pkg::CMD_CLEAR: begin
              ctl.clr  = 1'b1;
              ctl.emit = 1'b1;
              ctl.code = rgim_pkg::ST_CLEARED;
            end
            rgim_pkg::CMD_ADD: begin
              ctl.emit = 1'b1;
              if (sts.full) begin
                ctl.code = rgim_pkg::ST_DROPPED;
              end else begin
                ctl.wr   = 1'b1;
                ctl.code = rgim_pkg::ST_STORED;
              end
            end
            rgim_pkg::CMD_QUERY: begin
              ctl.init  = 1'b1;
              state_nxt = sts.empty ? rgim_pkg::S_FIN : rgim_pkg::S_RD;
            end
            rgim_pkg::CMD_NONE: ;
            default: ;
          endcase
        end
      end
      rgim_pkg::S_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = rgim_pkg::S_S1;
      end
      rgim_pkg::S_S1: begin
        ctl.s1    = 1'b1;
        state_nxt = rgim_pkg::S_S2;
      end
      rgim_pkg::S_S2: begin
        ctl.s2    = 1'b1;
        state_nxt = rgim_pkg::S_S3;
      end
      rgim_pkg::S_S3: begin
        ctl.s3    = 1'b1;
        state_nxt = rgim_pkg::S_DS;
      end
      rgim_pkg::S_DS: begin
        ctl.div_start = 1'b1;
        state_nxt     = rgim_pkg::S_DW;
      end
      rgim_pkg::S_DW: begin
        if (sts.div_done) begin
          state_nxt = rgim_pkg::S_UPD;
        end
      end
      rgim_pkg::S_UPD: begin
        ctl.upd = 1'b1;
        if (sts.last) begin
          state_nxt = rgim_pkg::S_FIN;
        end else begin
          ctl.k_inc = 1'b1;
          state_nxt = rgim_pkg::S_RD;
        end
      end
      rgim_pkg::S_FIN: begin
        ctl.emit  = 1'b1;
        ctl.code  = rgim_pkg::ST_QUERY;
        state_nxt = rgim_pkg::S_IDLE;
      end
      default: state_nxt = rgim_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != rgim_pkg::S_IDLE);

  a_upd_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgim_pkg::S_UPD && !sts.last) |=> state_r == rgim_pkg::S_RD)
    else $error("box walk did not continue");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && ctl.code != rgim_pkg::ST_QUERY) |-> state_r == rgim_pkg::S_IDLE)
    else $error("table transaction result outside idle");

endmodule

@@ hdl/roi_gt_iou_match.sv @@
// Top level: ROI to ground-truth IoU matcher with its controller and datapath.
// Clear and add commands are decoded in the idle state; their result strobes on out_valid
// the next cycle and the block can take a new command right away. A query walks the stored
// boxes one at a time: each box goes through a table read, three arithmetic stages, a divider
// start, 17 one-bit-per-cycle divide steps plus completion and a best-match update. The result
// is emitted after the update of the last box; an empty table skips the walk. All boxes share
// the one serial divider. busy is high for the whole query. Results are shown for exactly one
// cycle and cannot be held off.
module roi_gt_iou_match #(
  parameter int MAX_GT     = rgim_pkg::MAX_GT_DEF,
  parameter int COORD_BITS = rgim_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  rgim_pkg::in_t               in_data,
  output logic                        out_valid,
  output rgim_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rgim_pkg::THR_W-1:0]  cfg_data
);

  rgim_pkg::ctl_t ctl;
  rgim_pkg::sts_t sts;

  rgim_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  rgim_dp #(
    .MAX_GT     (MAX_GT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ dv/roi_gt_iou_match_test.sv @@
// Self-checking testbench for the ROI to ground-truth IoU matcher.
module roi_gt_iou_match_test;

  localparam int TABLE_DEPTH = rgim_pkg::MAX_GT_DEF;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rgim_pkg::in_t in_data;
  logic out_valid;
  rgim_pkg::out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [rgim_pkg::THR_W-1:0] cfg_data;

  roi_gt_iou_match dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int box_xmin[TABLE_DEPTH];
  int box_ymin[TABLE_DEPTH];
  int box_xmax[TABLE_DEPTH];
  int box_ymax[TABLE_DEPTH];
  logic [7:0] box_label[TABLE_DEPTH];
  int box_count;
  logic [rgim_pkg::THR_W-1:0] fg_thr, bgh_thr, bgl_thr;

  rgim_pkg::out_t match_queue[$];
  int errors;
  int n_results;
  int n_queries;
  int n_full_drops;

  typedef struct {
    rgim_pkg::in_t item;
    logic has_exp;
    rgim_pkg::out_t exp;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [16:0] iou_of(int rx0, int ry0, int rx1, int ry1, int k);
    longint iw, ih, inter, ra, ga, uni;
    iw = longint'(rx1 < box_xmax[k] ? rx1 : box_xmax[k]) -
         (rx0 > box_xmin[k] ? rx0 : box_xmin[k]) + 16;
    if (iw <= 0) return '0;
    ih = longint'(ry1 < box_ymax[k] ? ry1 : box_ymax[k]) -
         (ry0 > box_ymin[k] ? ry0 : box_ymin[k]) + 16;
    if (ih <= 0) return '0;
    inter = iw * ih;
    ra = (longint'(rx1) - rx0 + 16) * (longint'(ry1) - ry0 + 16);
    ga = (longint'(box_xmax[k]) - box_xmin[k] + 16) *
         (longint'(box_ymax[k]) - box_ymin[k] + 16);
    uni = ra + ga - inter;
    if (uni <= 0) return '0;
    return 17'((inter * 65536) / uni);
  endfunction

  // Advances the predicted table; returns 1 with the expected result when one is due.
  function automatic logic match_predict(input rgim_pkg::in_t it, output rgim_pkg::out_t res);
    int cx[4], cy[4];
    int xmn, xmx, ymn, ymx;
    logic [16:0] ov, best_ov;
    int best;
    res = '0;
    cx[0] = it.coord0; cy[0] = it.coord1; cx[1] = it.coord2; cy[1] = it.coord3;
    cx[2] = it.coord4; cy[2] = it.coord5; cx[3] = it.coord6; cy[3] = it.coord7;
    case (rgim_pkg::cmd_code_t'(it.cmd))
      rgim_pkg::CMD_CLEAR: begin
        box_count = 0;
        res.status = rgim_pkg::ST_CLEARED;
      end
      rgim_pkg::CMD_ADD: begin
        if (box_count >= TABLE_DEPTH) begin
          res.status = rgim_pkg::ST_DROPPED;
        end else begin
          xmn = cx[0]; xmx = cx[0]; ymn = cy[0]; ymx = cy[0];
          for (int i = 1; i < 4; i++) begin
            if (cx[i] < xmn) xmn = cx[i];
            if (cx[i] > xmx) xmx = cx[i];
            if (cy[i] < ymn) ymn = cy[i];
            if (cy[i] > ymx) ymx = cy[i];
          end
          box_xmin[box_count] = xmn; box_ymin[box_count] = ymn;
          box_xmax[box_count] = xmx; box_ymax[box_count] = ymx;
          box_label[box_count] = it.class_in;
          box_count++;
          res.status = rgim_pkg::ST_STORED;
        end
      end
      rgim_pkg::CMD_QUERY: begin
        best = 0;
        best_ov = '0;
        for (int k = 0; k < box_count; k++) begin
          ov = iou_of(cx[0], cy[0], cx[1], cy[1], k);
          if (k == 0 || ov > best_ov) begin
            best_ov = ov;
            best = k;
          end
        end
        res.status = rgim_pkg::ST_QUERY;
        res.best_index = 6'(best);
        res.max_overlap = best_ov;
        res.class_label = (box_count > 0) ? box_label[best] : 8'd0;
        res.is_fg = (best_ov >= fg_thr);
        res.is_bg = (best_ov >= bgl_thr) && (best_ov < bgh_thr);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (match_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        rgim_pkg::out_t e;
        e = match_queue.pop_front();
        if (out_data.status !== e.status || out_data.best_index !== e.best_index ||
            out_data.max_overlap !== e.max_overlap ||
            out_data.class_label !== e.class_label ||
            out_data.is_fg !== e.is_fg || out_data.is_bg !== e.is_bg) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
        end
      end
    end
  end

  // start stays high after an accepted transaction until the next call or a drain
  task automatic send_item(input rgim_pkg::in_t it, input int gap);
    rgim_pkg::out_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (match_predict(it, res)) begin
      match_queue = {match_queue, res};
      if (it.cmd == rgim_pkg::CMD_QUERY) n_queries++;
      if (res.status == rgim_pkg::ST_DROPPED) n_full_drops++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input rgim_pkg::reg_idx_t idx,
                           input logic [rgim_pkg::THR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rgim_pkg::REG_FG: fg_thr = val;
      rgim_pkg::REG_BGH: bgh_thr = val;
      rgim_pkg::REG_BGL: bgl_thr = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (match_queue.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (24 * TABLE_DEPTH + 10) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int near, int spread);
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    return 16'(near + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic rgim_pkg::in_t rand_box(int cxr, int cyr);
    rgim_pkg::in_t it;
    it = '0;
    it.cmd = rgim_pkg::CMD_ADD;
    it.coord0 = rand_coord(cxr, 300); it.coord1 = rand_coord(cyr, 300);
    it.coord2 = rand_coord(cxr, 300); it.coord3 = rand_coord(cyr, 300);
    it.coord4 = rand_coord(cxr, 300); it.coord5 = rand_coord(cyr, 300);
    it.coord6 = rand_coord(cxr, 300); it.coord7 = rand_coord(cyr, 300);
    it.class_in = 8'($urandom);
    return it;
  endfunction

  function automatic rgim_pkg::in_t rand_query(int cxr, int cyr);
    rgim_pkg::in_t it;
    int x0, y0;
    it = '0;
    it.cmd = rgim_pkg::CMD_QUERY;
    x0 = cxr - int'($urandom_range(0, 300));
    y0 = cyr - int'($urandom_range(0, 300));
    it.coord0 = 16'(x0); it.coord1 = 16'(y0);
    it.coord2 = 16'(x0 + int'($urandom_range(0, 600)));
    it.coord3 = 16'(y0 + int'($urandom_range(0, 600)));
    if ($urandom_range(0, 9) == 0) begin
      it.coord0 = 16'($urandom); it.coord1 = 16'($urandom);
      it.coord2 = 16'($urandom); it.coord3 = 16'($urandom);
    end
    it.coord4 = 16'($urandom); it.coord5 = 16'($urandom);
    it.coord6 = 16'($urandom); it.coord7 = 16'($urandom);
    it.class_in = 8'($urandom);
    return it;
  endfunction

  function automatic rgim_pkg::in_t mk(rgim_pkg::cmd_code_t c, int a, int b, int d, int e,
                                       logic [7:0] l);
    rgim_pkg::in_t it;
    it = '0;
    it.cmd = c;
    it.coord0 = 16'(a); it.coord1 = 16'(b); it.coord2 = 16'(d); it.coord3 = 16'(e);
    it.coord4 = 16'(a); it.coord5 = 16'(b); it.coord6 = 16'(d); it.coord7 = 16'(e);
    it.class_in = l;
    return it;
  endfunction

  function automatic rgim_pkg::out_t st(rgim_pkg::status_t s);
    rgim_pkg::out_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    rgim_pkg::out_t qz;
    int sets, cxr, cyr, nb;
    logic [rgim_pkg::THR_W-1:0] thr_a, thr_b;

    errors = 0; n_results = 0; n_queries = 0; n_full_drops = 0;
    box_count = 0;
    fg_thr = rgim_pkg::FG_RST; bgh_thr = rgim_pkg::BGH_RST; bgl_thr = rgim_pkg::BGL_RST;
    start = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_index = rgim_pkg::REG_FG; cfg_data = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty table query after reset: overlap 0, bg band [0,0.5) holds
    qz = st(rgim_pkg::ST_QUERY); qz.is_bg = 1'b1;
    r.item = mk(rgim_pkg::CMD_QUERY, 0, 0, 160, 160, 8'h00); r.has_exp = 1; r.exp = qz;
    rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_CLEAR, 0, 0, 0, 0, 8'h00); r.exp = st(rgim_pkg::ST_CLEARED);
    rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_ADD, 0, 0, 160, 160, 8'hFF); r.exp = st(rgim_pkg::ST_STORED);
    rows = {rows, r};
    // identical box: overlap 1.0
    qz = st(rgim_pkg::ST_QUERY); qz.max_overlap = 17'h10000; qz.class_label = 8'hFF;
    qz.is_fg = 1;
    r.item = mk(rgim_pkg::CMD_QUERY, 0, 0, 160, 160, 8'h00); r.exp = qz; rows = {rows, r};
    r.has_exp = 0;
    r.item = mk(rgim_pkg::CMD_ADD, 0, 0, 160, 160, 8'h11); rows = {rows, r};     // tie
    r.item = mk(rgim_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 8'h22); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_ADD, 32767, 32767, 32767, 32767, 8'h33); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_ADD, -32768, 32767, 32767, -32768, 8'h44); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_QUERY, 0, 0, 160, 160, 8'h00); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_QUERY, 5000, 5000, 5100, 5100, 8'h00); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_QUERY, 32767, 32767, 32767, 32767, 8'h00); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_QUERY, -32768, -32768, 32767, 32767, 8'hFF); rows = {rows, r};
    r.item = mk(rgim_pkg::CMD_QUERY, 200, 200, 100, 100, 8'h00); rows = {rows, r}; // inverted
    r.item = mk(rgim_pkg::CMD_QUERY, 176, 0, 300, 160, 8'h00); rows = {rows, r};   // touching
    r.item = mk(rgim_pkg::CMD_NONE, 1, 2, 3, 4, 8'h55); rows = {rows, r};         // no result
    r.item = mk(rgim_pkg::CMD_QUERY, 8, 8, 150, 150, 8'h00); rows = {rows, r};
    for (int i = 0; i < rows.size(); i++) begin
      send_item(rows[i].item, 0);
      if (rows[i].has_exp) match_queue[match_queue.size() - 1] = rows[i].exp;
    end
    drain();

    // extremes of thresholds
    write_reg(rgim_pkg::REG_FG, 17'h10000); write_reg(rgim_pkg::REG_BGH, 17'h1FFFF);
    write_reg(rgim_pkg::REG_BGL, 17'h10000);
    send_item(mk(rgim_pkg::CMD_QUERY, 0, 0, 160, 160, 8'h00), 0);
    send_item(mk(rgim_pkg::CMD_QUERY, 0, 0, 320, 160, 8'h00), 0);
    drain();
    write_reg(rgim_pkg::REG_FG, '0); write_reg(rgim_pkg::REG_BGH, '0);
    write_reg(rgim_pkg::REG_BGL, '0);
    send_item(mk(rgim_pkg::CMD_QUERY, 0, 0, 320, 160, 8'h00), 0);
    drain();

    // random sets: clear, load, query
    sets = 0;
    while (n_results < 1680) begin
      if (sets % 6 == 5) begin
        drain();
        thr_a = 17'($urandom_range(0, 65536));
        thr_b = 17'($urandom_range(0, 65536));
        write_reg(rgim_pkg::REG_FG, 17'($urandom_range(0, 65536)));
        write_reg(rgim_pkg::REG_BGH, thr_a > thr_b ? thr_a : thr_b);
        write_reg(rgim_pkg::REG_BGL, thr_a > thr_b ? thr_b : thr_a);
      end
      cxr = int'($urandom_range(0, 60000)) - 30000;
      cyr = int'($urandom_range(0, 60000)) - 30000;
      send_item(mk(rgim_pkg::CMD_CLEAR, int'($urandom), int'($urandom), 0, 0, 8'($urandom)),
                $urandom_range(0, 18));
      nb = (sets % 20 == 7) ? TABLE_DEPTH + 2 : $urandom_range(0, 6);
      for (int i = 0; i < nb; i++) begin
        send_item(rand_box(cxr, cyr), (nb > 10) ? 0 : $urandom_range(0, 18));
        if ($urandom_range(0, 3) == 0 && nb <= 10)
          send_item(rand_query(cxr, cyr), $urandom_range(0, 18));
      end
      for (int i = 0; i < ((nb > 10) ? 2 : 4); i++) begin
        send_item(rand_query(cxr, cyr), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
      end
      if ($urandom_range(0, 7) == 0)
        send_item(mk(rgim_pkg::CMD_NONE, int'($urandom), 0, 0, 0, 8'($urandom)),
                  $urandom_range(0, 18));
      sets++;
    end
    drain();

    $display("Ran %0d results incl. %0d queries and %0d full-table drops over %0d load sets.",
             n_results, n_queries, n_full_drops, sets);
    if (errors == 0 && match_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rgim_pkg.sv
hdl/rgim_div.sv
hdl/rgim_dp.sv
hdl/rgim_ctrl.sv
hdl/roi_gt_iou_match.sv
dv/roi_gt_iou_match_test.sv
